/* design/infix_to_postfix_converter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Concurrent checks sampled on aclk, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define IPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ipc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Types, codes and character tables shared by the converter modules.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int DEFAULT_STACK_DEPTH = 32;

    localparam int CODE_W = 3;
    localparam int PREC_W = 2;

    // Stack entry codes
    localparam logic [CODE_W-1:0] CODE_OPEN  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_PLUS  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_MINUS = 3'd2;
    localparam logic [CODE_W-1:0] CODE_MUL   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DIV   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_POW   = 3'd5;

    // Characters
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // End-of-expression status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OPEN     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_CLOSE    = 2'd3;

    // Input commands
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Character classes
    localparam logic [2:0] CLS_DROP  = 3'd0;
    localparam logic [2:0] CLS_ALNUM = 3'd1;
    localparam logic [2:0] CLS_OPEN  = 3'd2;
    localparam logic [2:0] CLS_CLOSE = 3'd3;
    localparam logic [2:0] CLS_OP    = 3'd4;

    // Output register load select
    localparam logic [1:0] EMIT_NONE = 2'd0;
    localparam logic [1:0] EMIT_CHAR = 2'd1;
    localparam logic [1:0] EMIT_TOP  = 2'd2;
    localparam logic [1:0] EMIT_END  = 2'd3;

    typedef struct packed {
        logic       command;
        logic [7:0] symbol_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] symbol_out;
        logic       end_marker;
        logic [1:0] status;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic       load_in;
        logic       push;
        logic       pop;
        logic       set_close_err;
        logic       set_open;
        logic       finish;
        logic [1:0] emit;
        logic       last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       is_end;
        logic       err_set;
        logic [2:0] cls;
        logic       count_zero;
        logic       count_one;
        logic       top_open;
        logic       top_ge;
        logic       next_lt;
        logic       next_open;
        logic       out_ok;
    } ctrl_status_t;

    function automatic logic [CODE_W-1:0] op_code(input logic [7:0] c);
        logic [CODE_W-1:0] code;
        case (c)
            CH_PLUS:  code = CODE_PLUS;
            CH_MINUS: code = CODE_MINUS;
            CH_MUL:   code = CODE_MUL;
            CH_DIV:   code = CODE_DIV;
            CH_POW:   code = CODE_POW;
            default:  code = CODE_OPEN;
        endcase
        return code;
    endfunction

    function automatic logic [PREC_W-1:0] code_prec(input logic [CODE_W-1:0] code);
        logic [PREC_W-1:0] p;
        case (code)
            CODE_PLUS, CODE_MINUS: p = 2'd1;
            CODE_MUL, CODE_DIV:    p = 2'd2;
            CODE_POW:              p = 2'd3;
            default:               p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] code_char(input logic [CODE_W-1:0] code);
        logic [7:0] c;
        case (code)
            CODE_OPEN:  c = CH_LPAREN;
            CODE_PLUS:  c = CH_PLUS;
            CODE_MINUS: c = CH_MINUS;
            CODE_MUL:   c = CH_MUL;
            CODE_DIV:   c = CH_DIV;
            CODE_POW:   c = CH_POW;
            default:    c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [2:0] cls;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39)) begin
            cls = CLS_ALNUM;
        end else if (c == CH_LPAREN) begin
            cls = CLS_OPEN;
        end else if (c == CH_RPAREN) begin
            cls = CLS_CLOSE;
        end else if (op_code(c) != CODE_OPEN) begin
            cls = CLS_OP;
        end else begin
            cls = CLS_DROP;
        end
        return cls;
    endfunction

endpackage

/* design/ipc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_ctrl
// Sequencer: takes one item, dispatches on its class and runs the pop loops.
// ----------------------------------------------------------------------------
module ipc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ipc_pkg::ctrl_status_t sts,
    output ipc_pkg::ctrl_cmd_t    cmd
);
    import ipc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CHAR  = 3'd2;
    localparam logic [2:0] S_OPER  = 3'd3;
    localparam logic [2:0] S_CLOSE = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;
    localparam logic [2:0] S_END   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = EMIT_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.is_end) begin
                    state_next = sts.err_set ? S_END : S_FLUSH;
                end else if (sts.err_set) begin
                    // drop everything until the end command
                    state_next = S_IDLE;
                end else begin
                    unique case (sts.cls)
                        CLS_ALNUM: state_next = S_CHAR;
                        CLS_OPEN: begin
                            cmd.push   = 1'b1;
                            state_next = S_IDLE;
                        end
                        CLS_CLOSE: state_next = S_CLOSE;
                        CLS_OP:    state_next = S_OPER;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CHAR: begin
                if (sts.out_ok) begin
                    cmd.emit   = EMIT_CHAR;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OPER: begin
                if (sts.count_zero || !sts.top_ge) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end else if (sts.out_ok) begin
                    cmd.pop  = 1'b1;
                    cmd.emit = EMIT_TOP;
                    cmd.last = sts.count_one || sts.next_lt;
                end
            end
            S_CLOSE: begin
                if (sts.count_zero) begin
                    cmd.set_close_err = 1'b1;
                    state_next        = S_IDLE;
                end else if (sts.top_open) begin
                    cmd.pop    = 1'b1;
                    state_next = S_IDLE;
                end else if (sts.out_ok) begin
                    cmd.pop  = 1'b1;
                    cmd.emit = EMIT_TOP;
                    cmd.last = sts.count_one || sts.next_open;
                end
            end
            S_FLUSH: begin
                if (sts.count_zero) begin
                    state_next = S_END;
                end else if (sts.top_open) begin
                    cmd.pop      = 1'b1;
                    cmd.set_open = 1'b1;
                end else if (sts.out_ok) begin
                    cmd.pop  = 1'b1;
                    cmd.emit = EMIT_TOP;
                end
            end
            S_END: begin
                if (sts.out_ok) begin
                    cmd.emit   = EMIT_END;
                    cmd.last   = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/ipc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_datapath
// Item register, operator stack with a separate top entry, error state and
// the result register.
// ----------------------------------------------------------------------------
module ipc_datapath #(
    parameter int STACK_DEPTH = ipc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipc_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ipc_pkg::out_item_t    m_data,
    input  ipc_pkg::ctrl_cmd_t    cmd,
    output ipc_pkg::ctrl_status_t sts
);
    import ipc_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH - 1);

    logic              cmd_reg;
    logic [7:0]        sym_reg;
    logic [CODE_W-1:0] top_reg;
    logic [CODE_W-1:0] top_next;
    logic [CODE_W-1:0] below_reg [STACK_DEPTH-1];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [1:0]        error_reg;
    logic [1:0]        error_next;
    logic              open_seen_reg;
    logic              open_seen_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    out_item_t         m_data_reg;
    out_item_t         m_data_next;

    logic [CODE_W-1:0] cur_code;
    logic [PREC_W-1:0] cur_prec;
    logic [CODE_W-1:0] next_code;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic              full;
    logic              below_wr;

    assign cur_code = op_code(sym_reg);
    assign cur_prec = code_prec(cur_code);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));
    // entry under the top, only meaningful with two or more live entries
    assign next_code = (count_reg > CNT_W'(1)) ? below_reg[cnt_m2[IDX_W-1:0]] : CODE_OPEN;
    assign below_wr  = cmd.push && !full && (count_reg != '0);

    always_comb begin
        sts            = '0;
        sts.is_end     = (cmd_reg == CMD_END);
        sts.err_set    = (error_reg != ST_OK);
        sts.cls        = classify(sym_reg);
        sts.count_zero = (count_reg == '0);
        sts.count_one  = (count_reg == CNT_W'(1));
        sts.top_open   = (top_reg == CODE_OPEN);
        sts.top_ge     = (code_prec(top_reg) >= cur_prec);
        sts.next_lt    = (code_prec(next_code) < cur_prec);
        sts.next_open  = (next_code == CODE_OPEN);
        sts.out_ok     = !m_valid_reg || m_ready;
    end

    always_comb begin
        count_next     = count_reg;
        top_next       = top_reg;
        error_next     = error_reg;
        open_seen_next = open_seen_reg;
        if (cmd.push) begin
            if (full) begin
                if (error_reg == ST_OK) begin
                    error_next = ST_OVERFLOW;
                end
            end else begin
                top_next   = cur_code;
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.pop) begin
            top_next   = next_code;
            count_next = cnt_m1;
        end
        if (cmd.set_close_err && error_reg == ST_OK) begin
            error_next = ST_CLOSE;
        end
        if (cmd.set_open) begin
            open_seen_next = 1'b1;
        end
        if (cmd.finish) begin
            count_next     = '0;
            error_next     = ST_OK;
            open_seen_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (cmd.emit)
            EMIT_CHAR: begin
                m_valid_next = 1'b1;
                m_data_next  = '{symbol_out: sym_reg, end_marker: 1'b0,
                                 status: ST_OK, last_of_run: cmd.last};
            end
            EMIT_TOP: begin
                m_valid_next = 1'b1;
                m_data_next  = '{symbol_out: code_char(top_reg), end_marker: 1'b0,
                                 status: ST_OK, last_of_run: cmd.last};
            end
            EMIT_END: begin
                m_valid_next = 1'b1;
                m_data_next  = '{symbol_out: CH_NUL, end_marker: 1'b1,
                                 status: (error_reg != ST_OK) ? error_reg :
                                         (open_seen_reg ? ST_OPEN : ST_OK),
                                 last_of_run: cmd.last};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            error_reg     <= ST_OK;
            open_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            error_reg     <= error_next;
            open_seen_reg <= open_seen_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg <= s_data.command;
            sym_reg <= s_data.symbol_in;
        end
        top_reg    <= top_next;
        m_data_reg <= m_data_next;
        // spill the old top below the new one
        if (below_wr) begin
            below_reg[cnt_m1[IDX_W-1:0]] <= top_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/infix_to_postfix_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an ASCII infix stream to postfix.
// ----------------------------------------------------------------------------
// One item is in work at a time: S_IDLE accepts it and S_EXEC decodes it,
// which ends the work on a dropped character or a '('. A letter or digit
// then goes out through S_CHAR. An operator pops each stacked operator of
// equal or higher precedence, then is pushed; a ')' pops entries down to and
// including its '(', and an unmatched ')' pops every operator and flags an
// error. The end command pops every live stack entry and emits the end result,
// or emits it at once when an error is pending. The stack pops one entry a cycle
// unless a stalled m_ready holds a result in the output register.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = ipc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ipc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ipc_pkg::out_item_t m_data
);
    import ipc_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t sts;

    ipc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ipc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

/* design/ipc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_assert.svh"

module ipc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input ipc_pkg::out_item_t m_data
);
    import ipc_pkg::*;

    // hold a stalled result
    `IPC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    // one item in work at a time
    `IPC_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "input taken while an item is in work")
    `IPC_ASSERT_SAME(a_end_last, m_valid && m_data.end_marker, m_data.last_of_run && (m_data.symbol_out == CH_NUL), "end result malformed")
    `IPC_ASSERT_SAME(a_status_end, m_valid && !m_data.end_marker, m_data.status == ST_OK, "status set on a non-end result")

endmodule

bind infix_to_postfix_converter ipc_checker u_ipc_checker (.*);

/* dv/ipc_postfix_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_postfix_checker
// Watches both channels of the infix to postfix converter. It keeps its own
// operator stack and error status, works out the postfix results that each
// accepted input transfer causes, and compares every output transfer field by
// field against the oldest of them.
// ----------------------------------------------------------------------------
module ipc_postfix_checker #(
    parameter int STACK_DEPTH = ipc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  ipc_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  ipc_pkg::out_item_t m_data,
    output int                 fail_count,
    output int                 pending
);

    import ipc_pkg::*;

    logic [CODE_W-1:0] op_stack [STACK_DEPTH];
    int                depth_used;
    logic [1:0]        sticky_status;
    out_item_t         postfix_q [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] postfix mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic out_item_t make_result(input logic [7:0] sym, input logic endm,
                                              input logic [1:0] st);
        out_item_t res;
        res.symbol_out  = sym;
        res.end_marker  = endm;
        res.status      = st;
        res.last_of_run = 1'b0;
        return res;
    endfunction

    function automatic logic [7:0] code_symbol(input logic [CODE_W-1:0] code);
        case (code)
            CODE_PLUS:  return CH_PLUS;
            CODE_MINUS: return CH_MINUS;
            CODE_MUL:   return CH_MUL;
            CODE_DIV:   return CH_DIV;
            CODE_POW:   return CH_POW;
            default:    return CH_LPAREN;
        endcase
    endfunction

    // An open paren ranks below every operator, so popping stops on it
    function automatic int code_rank(input logic [CODE_W-1:0] code);
        case (code)
            CODE_PLUS, CODE_MINUS: return 1;
            CODE_MUL, CODE_DIV:    return 2;
            CODE_POW:              return 3;
            default:               return 0;
        endcase
    endfunction

    task automatic flag_error(input logic [1:0] st);
        if (sticky_status == ST_OK) begin
            sticky_status = st;
        end
    endtask

    task automatic push_code(input logic [CODE_W-1:0] code);
        if (depth_used >= STACK_DEPTH) begin
            flag_error(ST_OVERFLOW);
        end else begin
            op_stack[depth_used] = code;
            depth_used++;
        end
    endtask

    task automatic convert_symbol(input in_item_t item);
        out_item_t         run_q [$];
        out_item_t         res;
        logic [7:0]        c;
        logic [CODE_W-1:0] top;
        logic [CODE_W-1:0] code;
        logic [1:0]        st;
        bit                found;
        bit                is_op;
        c = item.symbol_in;
        if (item.command == CMD_END) begin
            st = sticky_status;
            // on error the stack is dropped silently
            if (st == ST_OK) begin
                while (depth_used > 0) begin
                    depth_used--;
                    top = op_stack[depth_used];
                    if (top == CODE_OPEN) begin
                        st = ST_OPEN;
                    end else begin
                        run_q.push_back(make_result(code_symbol(top), 1'b0, ST_OK));
                    end
                end
            end
            run_q.push_back(make_result(CH_NUL, 1'b1, st));
            depth_used    = 0;
            sticky_status = ST_OK;
        end else if (sticky_status == ST_OK) begin
            is_op = 1'b1;
            case (c)
                CH_PLUS:  code = CODE_PLUS;
                CH_MINUS: code = CODE_MINUS;
                CH_MUL:   code = CODE_MUL;
                CH_DIV:   code = CODE_DIV;
                CH_POW:   code = CODE_POW;
                default: begin
                    code  = CODE_OPEN;
                    is_op = 1'b0;
                end
            endcase
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
                run_q.push_back(make_result(c, 1'b0, ST_OK));
            end else if (c == CH_LPAREN) begin
                push_code(CODE_OPEN);
            end else if (c == CH_RPAREN) begin
                found = 1'b0;
                while (depth_used > 0 && !found) begin
                    depth_used--;
                    top = op_stack[depth_used];
                    if (top == CODE_OPEN) begin
                        found = 1'b1;
                    end else begin
                        run_q.push_back(make_result(code_symbol(top), 1'b0, ST_OK));
                    end
                end
                if (!found) begin
                    flag_error(ST_CLOSE);
                end
            end else if (is_op) begin
                while (depth_used > 0 && code_rank(op_stack[depth_used-1]) >= code_rank(code)) begin
                    depth_used--;
                    run_q.push_back(make_result(code_symbol(op_stack[depth_used]), 1'b0, ST_OK));
                end
                push_code(code);
            end
        end
        if (run_q.size() > 0) begin
            res = run_q.pop_back();
            res.last_of_run = 1'b1;
            run_q.push_back(res);
        end
        foreach (run_q[i]) begin
            postfix_q.push_back(run_q[i]);
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (postfix_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result symbol %02h end %0b status %0d",
                                      got.symbol_out, got.end_marker, got.status));
        end else begin
            want = postfix_q.pop_front();
            if (got.symbol_out !== want.symbol_out) begin
                report_mismatch($sformatf("symbol_out %02h, expected %02h",
                                          got.symbol_out, want.symbol_out));
            end
            if (got.end_marker !== want.end_marker) begin
                report_mismatch($sformatf("end_marker %0b, expected %0b",
                                          got.end_marker, want.end_marker));
            end
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            end
            if (got.last_of_run !== want.last_of_run) begin
                report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                          got.last_of_run, want.last_of_run));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            depth_used    = 0;
            sticky_status = ST_OK;
            postfix_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (s_valid && s_ready) begin
                convert_symbol(s_data);
            end
        end
        pending <= postfix_q.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives infix text into the converter: a short directed set, a phase that
// stalls the output long enough to back the block up and overflow its stack,
// then random expressions, broken text and deep nests, each closed by an end
// command. Gaps and stalls are random on both channels.
// ----------------------------------------------------------------------------
module tb;

    import ipc_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 460;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int         fail_count;
    int         pending;
    int         cycle_count;
    int         live_items;
    logic       long_hold_req;
    bit         no_gaps;
    logic [7:0] text_q [$];

    infix_to_postfix_converter u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ipc_postfix_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit is_live(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
               c == CH_LPAREN || c == CH_RPAREN || c == CH_PLUS || c == CH_MINUS ||
               c == CH_MUL || c == CH_DIV || c == CH_POW;
    endfunction

    function automatic logic [7:0] rand_alnum();
        case ($urandom_range(0, 2))
            0:       return 8'(8'h61 + $urandom_range(0, 25));
            1:       return 8'(8'h41 + $urandom_range(0, 25));
            default: return 8'(8'h30 + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_POW;
        endcase
    endfunction

    function automatic logic [7:0] rand_filler();
        case ($urandom_range(0, 2))
            0:       return " ";
            1:       return 8'h09;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] sym);
        in_item_t item;
        int       gap;
        item.command   = cmd;
        item.symbol_in = sym;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_data  <= in_item_t'(9'($urandom));
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_END || is_live(sym)) begin
            live_items++;
        end
    endtask

    // Send the queued text, then close the expression
    task automatic send_expression(input logic [7:0] end_sym);
        foreach (text_q[i]) begin
            send_item(CMD_CHAR, text_q[i]);
        end
        text_q.delete();
        send_item(CMD_END, end_sym);
    endtask

    task automatic queue_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Well-formed: operands and operators alternate, parens balance, some filler
    task automatic build_expr();
        int terms;
        int open_cnt;
        terms    = $urandom_range(1, 8);
        open_cnt = 0;
        for (int i = 0; i < terms; i++) begin
            while (open_cnt < 4 && $urandom_range(0, 3) == 0) begin
                text_q.push_back(CH_LPAREN);
                open_cnt++;
            end
            text_q.push_back(rand_alnum());
            while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
                text_q.push_back(CH_RPAREN);
                open_cnt--;
            end
            if ($urandom_range(0, 9) == 0) begin
                text_q.push_back(rand_filler());
            end
            if (i < terms - 1) begin
                text_q.push_back(rand_operator());
            end
        end
        repeat (open_cnt) text_q.push_back(CH_RPAREN);
    endtask

    task automatic build_broken();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 4))
                0:       text_q.push_back(rand_alnum());
                1:       text_q.push_back(rand_operator());
                2:       text_q.push_back(CH_LPAREN);
                3:       text_q.push_back(CH_RPAREN);
                default: text_q.push_back(rand_filler());
            endcase
        end
    endtask

    // Two stack entries per level; past sixteen levels the stack overflows
    task automatic build_nest(input int levels);
        repeat (levels) begin
            text_q.push_back(CH_LPAREN);
            text_q.push_back(rand_alnum());
            text_q.push_back(rand_operator());
        end
        text_q.push_back(rand_alnum());
        repeat ($urandom_range(0, levels + 1)) text_q.push_back(CH_RPAREN);
    endtask

    // Receiver: mostly ready, short and long stalls, one long hold-off on request
    initial begin
        bit hold_seen;
        int r;
        hold_seen = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (!long_hold_req) begin
                    hold_seen = 1'b0;
                end
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        int r;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_data        <= '0;
        long_hold_req <= 1'b0;
        no_gaps     = 1'b0;
        live_items  = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // precedence, the ^ operator, parens, extremes of the alphabet
        queue_string("a+b*c");
        send_expression(8'hFF);
        queue_string("(x-Z)/9^0");
        send_expression(8'h00);
        // dropped bytes, unmatched close, character ignored while in error
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        queue_string(" \t)a");
        send_expression(8'($urandom));
        // unmatched open
        queue_string("(a");
        send_expression(8'($urandom));

        // stall the output so the block backs up, and overflow the stack
        long_hold_req <= 1'b1;
        no_gaps = 1'b1;
        build_nest(17);
        send_expression(8'($urandom));
        build_expr();
        send_expression(8'($urandom));
        long_hold_req <= 1'b0;
        no_gaps = 1'b0;
        wait_drained();

        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                build_expr();
            end else if (r < 85) begin
                build_broken();
            end else begin
                build_nest($urandom_range(1, 20));
            end
            send_expression(8'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/ipc_pkg.sv
design/ipc_ctrl.sv
design/ipc_datapath.sv
design/infix_to_postfix_converter.sv
design/ipc_checker.sv
dv/ipc_postfix_checker.sv
dv/tb.sv
